/* rtl/core/qkc_pkg.sv */
`timescale 1ns / 1ps

package qkc_pkg;

    localparam int VALUE_WIDTH_DEF = 16;
    localparam int TIME_WIDTH_DEF  = 32;

    localparam int THRESH_W  = 24;
    localparam int FACTOR_W  = 4;
    localparam int SPN_W     = 3;
    localparam int SUM_W     = 4;
    localparam int DELTA_W   = 5;
    localparam int CFG_IDX_W = 3;
    localparam int REQ_W     = 2;

    localparam logic [REQ_W-1:0] REQ_PIN     = 2'd0;
    localparam logic [REQ_W-1:0] REQ_LOAD    = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CAPTURE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_VALUE_MIN    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VALUE_MAX    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT_MODE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPN          = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_EN     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FAST_THRESH  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_FACTOR = 3'd6;

    localparam logic       MODE_SUBSTEP = 1'b0;
    localparam logic       MODE_DETENT  = 1'b1;

    localparam logic [1:0] PINS_00 = 2'b00;
    localparam logic [1:0] PINS_01 = 2'b01;
    localparam logic [1:0] PINS_10 = 2'b10;
    localparam logic [1:0] PINS_11 = 2'b11;

    localparam int                  VALUE_MAX_RST  = 100;
    localparam logic [SPN_W-1:0]    SPN_RST        = 3'd4;
    localparam logic [THRESH_W-1:0] THRESH_RST     = 24'd50000;
    localparam logic [FACTOR_W-1:0] FACTOR_RST     = 4'd4;

    typedef struct packed {
        logic                      moved;
        logic                      accel;
        logic                      notch;
        logic signed [DELTA_W-1:0] delta;
    } upd_flags_t;

    // Gray transition table, indexed by previous pins and current pins.
    function automatic logic signed [1:0] gray_step(input logic [1:0] prev,
                                                     input logic [1:0] pins);
        logic signed [1:0] step;
        case ({prev, pins})
            4'd1, 4'd7, 4'd8, 4'd14:  step = 2'sd1;
            4'd2, 4'd4, 4'd11, 4'd13: step = -2'sd1;
            default:                  step = 2'sd0;
        endcase
        return step;
    endfunction

endpackage

/* rtl/core/qkc_update.sv */
`timescale 1ns / 1ps

module qkc_update #(
    parameter int VALUE_WIDTH = qkc_pkg::VALUE_WIDTH_DEF,
    parameter int TIME_WIDTH  = qkc_pkg::TIME_WIDTH_DEF
) (
    input  logic signed [VALUE_WIDTH-1:0]       cfg_value_min,
    input  logic signed [VALUE_WIDTH-1:0]       cfg_value_max,
    input  logic                                cfg_count_mode,
    input  logic [qkc_pkg::SPN_W-1:0]           cfg_spn,
    input  logic                                cfg_accel_en,
    input  logic [qkc_pkg::THRESH_W-1:0]        cfg_fast_thresh,
    input  logic [qkc_pkg::FACTOR_W-1:0]        cfg_accel_factor,
    input  logic [qkc_pkg::REQ_W-1:0]           req_type,
    input  logic                                pin_a,
    input  logic                                pin_b,
    input  logic [TIME_WIDTH-1:0]               time_us,
    input  logic signed [VALUE_WIDTH-1:0]       new_value,
    input  logic [1:0]                          last_pins,
    input  logic signed [qkc_pkg::SUM_W-1:0]    substep_sum,
    input  logic signed [VALUE_WIDTH-1:0]       counter,
    input  logic [TIME_WIDTH-1:0]               last_notch_time,
    output logic [1:0]                          last_pins_next,
    output logic signed [qkc_pkg::SUM_W-1:0]    substep_sum_next,
    output logic signed [VALUE_WIDTH-1:0]       counter_next,
    output logic [TIME_WIDTH-1:0]               last_notch_time_next,
    output qkc_pkg::upd_flags_t                 flags
);
    import qkc_pkg::*;

    localparam int CMP_W = (TIME_WIDTH > THRESH_W) ? TIME_WIDTH : THRESH_W;

    logic [1:0]                  pins;
    logic signed [1:0]           gstep;
    logic [SPN_W-1:0]            spn;
    logic signed [SUM_W:0]       sum_ext;
    logic signed [SUM_W:0]       spn_s;
    logic                        reach;
    logic [TIME_WIDTH-1:0]       interval;
    logic                        fast;
    logic                        is_pin;
    logic                        sub_notch;
    logic                        det_move;
    logic                        det_down;
    logic                        neg;
    logic [FACTOR_W-1:0]         mag;
    logic signed [DELTA_W-1:0]   delta;
    logic                        moved;
    logic signed [VALUE_WIDTH:0] base;
    logic signed [VALUE_WIDTH:0] min_ext;
    logic signed [VALUE_WIDTH:0] max_ext;
    logic signed [VALUE_WIDTH:0] lo_clamped;
    logic signed [VALUE_WIDTH:0] clamped;

    always_comb begin
        pins      = {pin_a, pin_b};
        is_pin    = (req_type == REQ_PIN);
        gstep     = gray_step(last_pins, pins);
        spn       = (cfg_spn == '0) ? SPN_W'(1) : cfg_spn;
        sum_ext   = (SUM_W + 1)'(substep_sum) + (SUM_W + 1)'(gstep);
        spn_s     = $signed({2'b00, spn});
        reach     = (sum_ext >= spn_s) || (sum_ext <= -spn_s);
        interval  = time_us - last_notch_time;
        fast      = cfg_accel_en && (interval != '0)
                    && (CMP_W'(interval) < CMP_W'(cfg_fast_thresh));
        sub_notch = is_pin && (cfg_count_mode == MODE_SUBSTEP) && (gstep != 2'sd0) && reach;

        det_move  = ((pins == PINS_00) || (pins == PINS_11))
                    && ((last_pins == PINS_01) || (last_pins == PINS_10));
        det_down  = ((pins == PINS_00) && (last_pins == PINS_01))
                    || ((pins == PINS_11) && (last_pins == PINS_10));

        neg   = (cfg_count_mode == MODE_DETENT) ? det_down : sum_ext[SUM_W];
        mag   = (sub_notch && fast) ? cfg_accel_factor : FACTOR_W'(1);
        delta = neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
        moved = is_pin && ((cfg_count_mode == MODE_DETENT) ? det_move : sub_notch);

        flags.moved = moved;
        flags.accel = sub_notch && fast;
        flags.notch = sub_notch;
        flags.delta = moved ? delta : '0;

        min_ext = (VALUE_WIDTH + 1)'(cfg_value_min);
        max_ext = (VALUE_WIDTH + 1)'(cfg_value_max);
        if (req_type == REQ_LOAD) begin
            base = (VALUE_WIDTH + 1)'(new_value);
        end else begin
            base = (VALUE_WIDTH + 1)'(counter) + (VALUE_WIDTH + 1)'(delta);
        end
        lo_clamped = (base < min_ext) ? min_ext : base;
        clamped    = (lo_clamped > max_ext) ? max_ext : lo_clamped;

        counter_next = ((req_type == REQ_LOAD) || moved) ? clamped[VALUE_WIDTH-1:0] : counter;

        if (is_pin && (cfg_count_mode == MODE_SUBSTEP) && (gstep != 2'sd0)) begin
            substep_sum_next = reach ? '0 : sum_ext[SUM_W-1:0];
        end else begin
            substep_sum_next = substep_sum;
        end

        last_pins_next       = (is_pin || (req_type == REQ_CAPTURE)) ? pins : last_pins;
        last_notch_time_next = sub_notch ? time_us : last_notch_time;
    end

endmodule

/* rtl/core/quadrature_knob_counter_accel_core.sv */
`timescale 1ns / 1ps
// Throughput: one input beat and one result beat per cycle while the output is not
// stalled; an accepted beat waits in the input register, its result in the result
// register, and the counter update between them is a table lookup, one add and a clamp.
// Reset (aresetn low, synchronous) clears both stages, the pin, sum, counter and
// notch time state, and loads the configuration registers with their defaults.
module quadrature_knob_counter_accel_core #(
    parameter int VALUE_WIDTH = qkc_pkg::VALUE_WIDTH_DEF,
    parameter int TIME_WIDTH  = qkc_pkg::TIME_WIDTH_DEF
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic                                          cfg_wr_en,
    input  logic [qkc_pkg::CFG_IDX_W-1:0]                 cfg_addr,
    input  logic [((VALUE_WIDTH > qkc_pkg::THRESH_W) ? VALUE_WIDTH
                   : qkc_pkg::THRESH_W)-1:0]              cfg_wdata,
    input  logic                                          s_axis_tvalid,
    output logic                                          s_axis_tready,
    // pin_a, pin_b, time_us, new_value
    input  logic [((VALUE_WIDTH + TIME_WIDTH + 2 + 7) / 8) * 8 - 1:0] s_axis_tdata,
    // req_type
    input  logic [qkc_pkg::REQ_W-1:0]                     s_axis_tuser,
    output logic                                          m_axis_tvalid,
    input  logic                                          m_axis_tready,
    // count_value, moved, step_delta, accelerated
    output logic [((VALUE_WIDTH + 7 + 7) / 8) * 8 - 1:0]  m_axis_tdata
);
    import qkc_pkg::*;

    localparam int OUT_W  = ((VALUE_WIDTH + 7 + 7) / 8) * 8;
    localparam int TIME_LO = 2;
    localparam int VAL_LO  = 2 + TIME_WIDTH;

    logic signed [VALUE_WIDTH-1:0] value_min_reg;
    logic signed [VALUE_WIDTH-1:0] value_max_reg;
    logic                          count_mode_reg;
    logic [SPN_W-1:0]              spn_reg;
    logic                          accel_en_reg;
    logic [THRESH_W-1:0]           thresh_reg;
    logic [FACTOR_W-1:0]           factor_reg;

    logic [1:0]                    last_pins_reg;
    logic signed [SUM_W-1:0]       sum_reg;
    logic signed [VALUE_WIDTH-1:0] counter_reg;
    logic [TIME_WIDTH-1:0]         notch_time_reg;

    logic [1:0]                    last_pins_next;
    logic signed [SUM_W-1:0]       sum_next;
    logic signed [VALUE_WIDTH-1:0] counter_next;
    logic [TIME_WIDTH-1:0]         notch_time_next;
    upd_flags_t                    flags;

    logic                          in_valid_reg;
    logic [REQ_W-1:0]              in_req_reg;
    logic                          in_pin_a_reg;
    logic                          in_pin_b_reg;
    logic [TIME_WIDTH-1:0]         in_time_reg;
    logic signed [VALUE_WIDTH-1:0] in_value_reg;

    logic                          out_valid_reg;
    logic [OUT_W-1:0]              out_data_reg;

    logic                          advance;
    logic                          fire;

    assign advance       = !out_valid_reg || m_axis_tready;
    assign fire          = in_valid_reg && advance;
    assign s_axis_tready = !in_valid_reg || advance;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            value_min_reg  <= '0;
            value_max_reg  <= VALUE_WIDTH'(VALUE_MAX_RST);
            count_mode_reg <= MODE_SUBSTEP;
            spn_reg        <= SPN_RST;
            accel_en_reg   <= 1'b0;
            thresh_reg     <= THRESH_RST;
            factor_reg     <= FACTOR_RST;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_VALUE_MIN:    value_min_reg  <= cfg_wdata[VALUE_WIDTH-1:0];
                CFG_VALUE_MAX:    value_max_reg  <= cfg_wdata[VALUE_WIDTH-1:0];
                CFG_COUNT_MODE:   count_mode_reg <= cfg_wdata[0];
                CFG_SPN:          spn_reg        <= cfg_wdata[SPN_W-1:0];
                CFG_ACCEL_EN:     accel_en_reg   <= cfg_wdata[0];
                CFG_FAST_THRESH:  thresh_reg     <= cfg_wdata[THRESH_W-1:0];
                CFG_ACCEL_FACTOR: factor_reg     <= cfg_wdata[FACTOR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            in_req_reg   <= s_axis_tuser;
            in_pin_a_reg <= s_axis_tdata[0];
            in_pin_b_reg <= s_axis_tdata[1];
            in_time_reg  <= s_axis_tdata[TIME_LO +: TIME_WIDTH];
            in_value_reg <= s_axis_tdata[VAL_LO +: VALUE_WIDTH];
        end
    end

    qkc_update #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .TIME_WIDTH  (TIME_WIDTH)
    ) u_update (
        .cfg_value_min        (value_min_reg),
        .cfg_value_max        (value_max_reg),
        .cfg_count_mode       (count_mode_reg),
        .cfg_spn              (spn_reg),
        .cfg_accel_en         (accel_en_reg),
        .cfg_fast_thresh      (thresh_reg),
        .cfg_accel_factor     (factor_reg),
        .req_type             (in_req_reg),
        .pin_a                (in_pin_a_reg),
        .pin_b                (in_pin_b_reg),
        .time_us              (in_time_reg),
        .new_value            (in_value_reg),
        .last_pins            (last_pins_reg),
        .substep_sum          (sum_reg),
        .counter              (counter_reg),
        .last_notch_time      (notch_time_reg),
        .last_pins_next       (last_pins_next),
        .substep_sum_next     (sum_next),
        .counter_next         (counter_next),
        .last_notch_time_next (notch_time_next),
        .flags                (flags)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_pins_reg  <= '0;
            sum_reg        <= '0;
            counter_reg    <= '0;
            notch_time_reg <= '0;
        end else if (fire) begin
            last_pins_reg  <= last_pins_next;
            sum_reg        <= sum_next;
            counter_reg    <= counter_next;
            notch_time_reg <= notch_time_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            out_data_reg <= OUT_W'({flags.accel, flags.delta, flags.moved, counter_next});
        end
    end

    // The result beat holds its contents while the downstream side stalls.
    a_accel_implies_moved: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && flags.accel |-> flags.moved)
        else $error("acceleration flagged without a counted notch");

    a_idle_delta_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && !flags.moved |-> flags.delta == '0)
        else $error("nonzero step without a counted notch");

    a_sum_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        sum_reg != {1'b1, {(SUM_W - 1){1'b0}}})
        else $error("substep sum out of range");

    a_notch_clears_sum: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && flags.notch |=> sum_reg == '0 && notch_time_reg == $past(in_time_reg))
        else $error("notch did not clear the sum or record its time");

    a_reset_empty: assert property (@(posedge aclk)
        $past(!aresetn) |-> !out_valid_reg && !in_valid_reg)
        else $error("pipeline not empty after reset");

endmodule
